FILE: rtl/bmc_pkg.sv
// Battery monitor conversion: shared types, constants and the sequencer microcode.
// Used by bmc_div and battery_monitor_conversion_core. No dependencies.
package bmc_pkg;

    // Field widths
    localparam int ADC_W   = 12;
    localparam int MV_W    = 14;
    localparam int VBAT_W  = 24;
    localparam int OUT16_W = 16;
    localparam int BS_W    = 2;

    // Stream and configuration port widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Shared divider: 32-bit dividend, 14-bit divisor, two quotient bits a cycle
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 14;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Datapath work register
    localparam int ACC_W = 34;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FULL  = CFG_IDX_W'(1);

    localparam logic [MV_W-1:0] EMPTY_RST = MV_W'(3500);
    localparam logic [MV_W-1:0] FULL_RST  = MV_W'(4200);

    // Battery state codes
    localparam logic [BS_W-1:0] BS_UNKNOWN     = 2'd0;
    localparam logic [BS_W-1:0] BS_FULL        = 2'd1;
    localparam logic [BS_W-1:0] BS_CHARGING    = 2'd2;
    localparam logic [BS_W-1:0] BS_DISCHARGING = 2'd3;

    // Arithmetic constants
    localparam logic [ADC_W-1:0]     VBAT_SCALE  = ADC_W'(2400);
    localparam logic [ADC_W-1:0]     REF_MV      = ADC_W'(1200);
    localparam logic signed [ACC_W-1:0] PCT_SCALE  = ACC_W'(100);
    localparam logic signed [ACC_W-1:0] T25_MV     = ACC_W'(1430);
    localparam logic signed [ACC_W-1:0] SLOPE_NUM  = ACC_W'(10);
    localparam logic [DEN_W-1:0]     SLOPE_DEN   = DEN_W'(43);
    localparam logic signed [ACC_W-1:0] T_BASE     = ACC_W'(25);

    // Microcode
    localparam int STEP_W = 4;

    typedef enum logic [3:0] {
        OP_CLEAR,
        OP_VBT_DIV,
        OP_MV_STORE,
        OP_PCT_DIFF,
        OP_PCT_DIV,
        OP_PCT_STORE,
        OP_TMP_DIV,
        OP_VT_STORE,
        OP_T_SCALE,
        OP_T_DIV,
        OP_DEG_STORE,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_ERR,
        C_DIVBUSY,
        C_OUTBUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_EMIT  = STEP_W'(11);

    function automatic ctrl_t microcode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{op: OP_EMIT, cond: C_OUTBUSY, target: STEP_EMIT};
        case (step)
            4'd0:  c = '{op: OP_CLEAR,     cond: C_ERR,     target: STEP_EMIT};
            4'd1:  c = '{op: OP_VBT_DIV,   cond: C_NEXT,    target: STEP_FIRST};
            4'd2:  c = '{op: OP_MV_STORE,  cond: C_DIVBUSY, target: 4'd2};
            4'd3:  c = '{op: OP_PCT_DIFF,  cond: C_NEXT,    target: STEP_FIRST};
            4'd4:  c = '{op: OP_PCT_DIV,   cond: C_NEXT,    target: STEP_FIRST};
            4'd5:  c = '{op: OP_PCT_STORE, cond: C_DIVBUSY, target: 4'd5};
            4'd6:  c = '{op: OP_TMP_DIV,   cond: C_NEXT,    target: STEP_FIRST};
            4'd7:  c = '{op: OP_VT_STORE,  cond: C_DIVBUSY, target: 4'd7};
            4'd8:  c = '{op: OP_T_SCALE,   cond: C_NEXT,    target: STEP_FIRST};
            4'd9:  c = '{op: OP_T_DIV,     cond: C_NEXT,    target: STEP_FIRST};
            4'd10: c = '{op: OP_DEG_STORE, cond: C_DIVBUSY, target: 4'd10};
            default: c = '{op: OP_EMIT,    cond: C_OUTBUSY, target: STEP_EMIT};
        endcase
        return c;
    endfunction

    function automatic logic signed [OUT16_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [OUT16_W-1:0] r;
        if (v > ACC_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -ACC_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[OUT16_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/bmc_div.sv
// Battery monitor conversion: shared unsigned restoring divider, two quotient bits a cycle.
// Depends on bmc_pkg.
module bmc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bmc_pkg::NUM_W-1:0]   dividend,
    input  logic [bmc_pkg::DEN_W-1:0]   divisor,
    output logic                        busy,
    output logic [bmc_pkg::NUM_W-1:0]   quotient
);

    logic                         busy_reg, busy_next;
    logic [bmc_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [bmc_pkg::NUM_W-1:0]    q_reg, q_next;
    logic [bmc_pkg::DEN_W:0]      rem_reg, rem_next;
    logic [bmc_pkg::DEN_W-1:0]    den_reg, den_next;
    logic [bmc_pkg::DEN_W:0]      rem_a, rem_b;
    logic [bmc_pkg::NUM_W-1:0]    q_a;

    always_comb begin
        // first bit
        rem_a = {rem_reg[bmc_pkg::DEN_W-1:0], q_reg[bmc_pkg::NUM_W-1]};
        q_a   = {q_reg[bmc_pkg::NUM_W-2:0], 1'b0};
        if (rem_a >= {1'b0, den_reg}) begin
            rem_a  = rem_a - {1'b0, den_reg};
            q_a[0] = 1'b1;
        end
        // second bit
        rem_b  = {rem_a[bmc_pkg::DEN_W-1:0], q_a[bmc_pkg::NUM_W-1]};
        q_next = {q_a[bmc_pkg::NUM_W-2:0], 1'b0};
        if (rem_b >= {1'b0, den_reg}) begin
            rem_b     = rem_b - {1'b0, den_reg};
            q_next[0] = 1'b1;
        end
        rem_next  = rem_b;
        den_next  = den_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            den_next  = divisor;
            busy_next = 1'b1;
            cnt_next  = bmc_pkg::CNT_W'(bmc_pkg::DIV_STEPS - 1);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end else begin
            q_next   = q_reg;
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/battery_monitor_conversion_core.sv
// Battery monitor conversion core: microcoded sequencer around one shared divider.
// Depends on bmc_pkg and bmc_div.
//
//  channel | dir | ports                               | transfer when
//  s_      | in  | s_tvalid s_tready s_tdata[39:0]     | s_tvalid & s_tready
//  m_      | out | m_tvalid m_tready m_tdata[63:0]     | m_tvalid & m_tready
//  cfg_    | in  | cfg_valid cfg_ready cfg_index cfg_data | cfg_valid & cfg_ready
//
// From its transfer to m_tvalid an item runs through four passes of the shared
// divider (voltage, percent, sensor voltage, temperature slope), each with a start and a
// store step, plus four other steps. A zero divisor skips to the emit step.
// s_tready returns the cycle after emit, so a new item is taken only once the last one
// has been emitted.
// Synchronous active-low reset; registers come up at 3500 mV / 4200 mV, state unknown.
// s_tready is low while an item is in the sequencer; a finished result is held in the
// output register and the emit step stalls only if that register is still occupied.
module battery_monitor_conversion_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // ref_reading, temp_reading, vbat_reading, usb_power, charge_done, zero pad
    input  logic [bmc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // vbat_millivolts, charge_percent, temp_degrees, battery_state, state_changed,
    // divide_error, zero pad
    output logic [bmc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmc_pkg::CFG_DAT_W-1:0]     cfg_data
);

    logic [bmc_pkg::MV_W-1:0]             empty_reg, full_reg;
    logic                                 run_reg, run_next;
    logic [bmc_pkg::STEP_W-1:0]           step_reg, step_next;
    logic [bmc_pkg::ADC_W-1:0]            ref_reg, tmp_reg, vbt_reg;
    logic [bmc_pkg::BS_W-1:0]             last_reg, last_next;
    logic [bmc_pkg::BS_W-1:0]             bs_reg, bs_next;
    logic                                 chg_reg, chg_next;
    logic [bmc_pkg::VBAT_W-1:0]           mv_reg, mv_next;
    logic signed [bmc_pkg::OUT16_W-1:0]   pct_reg, pct_next;
    logic signed [bmc_pkg::OUT16_W-1:0]   deg_reg, deg_next;
    logic signed [bmc_pkg::ACC_W-1:0]     p_reg, p_next;
    logic                                 neg_reg, neg_next;
    logic                                 mvalid_reg, mvalid_next;
    logic [bmc_pkg::M_TDATA_W-1:0]        mdata_reg, mdata_next;

    bmc_pkg::ctrl_t                       ctrl;
    logic                                 s_xfer, err, div_busy, out_blocked, hold, jump;
    logic signed [bmc_pkg::DEN_W:0]       span;
    logic [bmc_pkg::DEN_W-1:0]            span_abs;
    logic                                 div_start;
    logic [bmc_pkg::NUM_W-1:0]            div_num, div_q;
    logic [bmc_pkg::DEN_W-1:0]            div_den;
    logic signed [bmc_pkg::ACC_W-1:0]     q_ext, q_sgn, diff, p_abs;
    logic [bmc_pkg::BS_W-1:0]             bs_in;

    assign s_xfer      = s_tvalid && s_tready;
    assign s_tready    = !run_reg;
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = mvalid_reg;
    assign m_tdata     = mdata_reg;

    assign span     = $signed({1'b0, full_reg}) - $signed({1'b0, empty_reg});
    assign span_abs = span[bmc_pkg::DEN_W] ? bmc_pkg::DEN_W'(-span)
                                           : span[bmc_pkg::DEN_W-1:0];
    assign err      = (ref_reg == '0) || (span == '0);

    assign ctrl        = bmc_pkg::microcode(step_reg);
    assign out_blocked = mvalid_reg && !m_tready;
    assign hold        = ((ctrl.cond == bmc_pkg::C_DIVBUSY) && div_busy)
                      || ((ctrl.cond == bmc_pkg::C_OUTBUSY) && out_blocked);
    assign jump        = hold || ((ctrl.cond == bmc_pkg::C_ERR) && err);

    assign q_ext = $signed({2'b00, div_q});
    assign q_sgn = neg_reg ? -q_ext : q_ext;
    assign diff  = $signed({10'b0, mv_reg}) - $signed({20'b0, empty_reg});
    assign p_abs = p_reg[bmc_pkg::ACC_W-1] ? -p_reg : p_reg;

    always_comb begin
        if (s_tdata[36]) begin
            bs_in = s_tdata[37] ? bmc_pkg::BS_FULL : bmc_pkg::BS_CHARGING;
        end else begin
            bs_in = bmc_pkg::BS_DISCHARGING;
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (ctrl.op)
            bmc_pkg::OP_VBT_DIV: begin
                div_start = run_reg;
                div_num   = bmc_pkg::NUM_W'(vbt_reg) * bmc_pkg::NUM_W'(bmc_pkg::VBAT_SCALE);
                div_den   = bmc_pkg::DEN_W'(ref_reg);
            end
            bmc_pkg::OP_PCT_DIV: begin
                div_start = run_reg;
                div_num   = p_abs[bmc_pkg::NUM_W-1:0];
                div_den   = span_abs;
            end
            bmc_pkg::OP_TMP_DIV: begin
                div_start = run_reg;
                div_num   = bmc_pkg::NUM_W'(tmp_reg) * bmc_pkg::NUM_W'(bmc_pkg::REF_MV);
                div_den   = bmc_pkg::DEN_W'(ref_reg);
            end
            bmc_pkg::OP_T_DIV: begin
                div_start = run_reg;
                div_num   = p_abs[bmc_pkg::NUM_W-1:0];
                div_den   = bmc_pkg::SLOPE_DEN;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bmc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb begin
        run_next    = run_reg;
        step_next   = step_reg;
        last_next   = last_reg;
        bs_next     = bs_reg;
        chg_next    = chg_reg;
        mv_next     = mv_reg;
        pct_next    = pct_reg;
        deg_next    = deg_reg;
        p_next      = p_reg;
        neg_next    = neg_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;

        if (s_xfer) begin
            run_next  = 1'b1;
            step_next = bmc_pkg::STEP_FIRST;
            bs_next   = bs_in;
            chg_next  = (bs_in != last_reg);
            last_next = bs_in;
        end else if (run_reg) begin
            step_next = jump ? ctrl.target : step_reg + 1'b1;
            if (!hold) begin
                case (ctrl.op)
                    bmc_pkg::OP_CLEAR: begin
                        mv_next  = '0;
                        pct_next = '0;
                        deg_next = '0;
                    end
                    bmc_pkg::OP_VBT_DIV: begin
                        neg_next = 1'b0;
                    end
                    bmc_pkg::OP_MV_STORE: begin
                        mv_next = div_q[bmc_pkg::VBAT_W-1:0];
                    end
                    bmc_pkg::OP_PCT_DIFF: begin
                        p_next = diff * bmc_pkg::PCT_SCALE;
                    end
                    bmc_pkg::OP_PCT_DIV: begin
                        neg_next = p_reg[bmc_pkg::ACC_W-1] ^ span[bmc_pkg::DEN_W];
                    end
                    bmc_pkg::OP_PCT_STORE: begin
                        pct_next = bmc_pkg::sat16(q_sgn);
                    end
                    bmc_pkg::OP_TMP_DIV: begin
                        neg_next = 1'b0;
                    end
                    bmc_pkg::OP_VT_STORE: begin
                        p_next = bmc_pkg::T25_MV - q_ext;
                    end
                    bmc_pkg::OP_T_SCALE: begin
                        p_next = p_reg * bmc_pkg::SLOPE_NUM;
                    end
                    bmc_pkg::OP_T_DIV: begin
                        neg_next = p_reg[bmc_pkg::ACC_W-1];
                    end
                    bmc_pkg::OP_DEG_STORE: begin
                        deg_next = bmc_pkg::sat16(q_sgn + bmc_pkg::T_BASE);
                    end
                    bmc_pkg::OP_EMIT: begin
                        mvalid_next = 1'b1;
                        mdata_next  = {4'b0, err, chg_reg, bs_reg,
                                       deg_reg, pct_reg, mv_reg};
                        run_next    = 1'b0;
                    end
                    default: begin
                        run_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_reg  <= bmc_pkg::EMPTY_RST;
            full_reg   <= bmc_pkg::FULL_RST;
            run_reg    <= 1'b0;
            step_reg   <= bmc_pkg::STEP_FIRST;
            last_reg   <= bmc_pkg::BS_UNKNOWN;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == bmc_pkg::REG_EMPTY) begin
                    empty_reg <= cfg_data[bmc_pkg::MV_W-1:0];
                end else if (cfg_index == bmc_pkg::REG_FULL) begin
                    full_reg <= cfg_data[bmc_pkg::MV_W-1:0];
                end
            end
            run_reg    <= run_next;
            step_reg   <= step_next;
            last_reg   <= last_next;
            mvalid_reg <= mvalid_next;
        end
        if (s_xfer) begin
            ref_reg <= s_tdata[11:0];
            tmp_reg <= s_tdata[23:12];
            vbt_reg <= s_tdata[35:24];
        end
        bs_reg    <= bs_next;
        chg_reg   <= chg_next;
        mv_reg    <= mv_next;
        pct_reg   <= pct_next;
        deg_reg   <= deg_next;
        p_reg     <= p_next;
        neg_reg   <= neg_next;
        mdata_reg <= mdata_next;
    end

endmodule
